/* rtl/adft_pkg.sv */
package adft_pkg;

    // Frame geometry
    localparam int FrameLen   = 16;
    localparam int PosW       = 5;                 // alarm frame + data frame positions
    localparam int QueueDepth = 2;

    localparam logic [7:0] AlarmByte = 8'hFF;
    localparam int         AlarmHead = 3;          // leading 0xFF bytes of an alarm frame

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_VOLT_CH   = 3'd0,
        CFG_TEMP_CH   = 3'd1,
        CFG_DECIMATE  = 3'd2,
        CFG_VLIMIT    = 3'd3,
        CFG_TRIP      = 3'd4
    } t_cfg_reg;

    localparam logic [7:0]  RstVoltCh   = 8'd6;
    localparam logic [7:0]  RstTempCh   = 8'd23;
    localparam logic [15:0] RstDecimate = 16'd3;
    localparam logic [11:0] RstVLimit   = 12'd819;
    localparam logic [15:0] RstTrip     = 16'd3;

    // Input beat
    typedef struct packed {
        logic [7:0]  channel;
        logic [11:0] sample;
    } t_in;

    // Output beat
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
        logic       dac_clear;
    } t_out;

    // Work handed from front to back: one data frame, optionally preceded by an alarm frame
    typedef struct packed {
        logic        alarm;
        logic [7:0]  channel;
        logic [11:0] sample;
    } t_job;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

endpackage

/* rtl/adc_decimate_frame_overvolt_trip_unit.sv */
// ADC decimation and over-voltage trip. Each accepted conversion beat is routed to the
// voltage or temperature channel; every (decimation_count+1)-th sample of a channel is sent
// as a 16-byte frame (channel, sample low byte, sample high nibble, 13 zeros). Decimated
// voltage samples feed an over-limit qualifier; on a trip a 16-byte alarm frame
// (FF FF FF, 13 zeros, dac_clear on its first byte) goes out ahead of the data frame.
// Input beats are accepted one per cycle while the two-entry job queue has room; beats that
// produce no frame never enter the queue. The back-end serializer drives one output byte per
// cycle while the output is not stalled, so a framed sample takes 16 bytes and a trip 32 bytes
// of output; last marks the final byte of each sample's run. Configuration writes take effect
// at the next edge and must be made while no bytes are pending.
module adc_decimate_frame_overvolt_trip_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  adft_pkg::t_in    i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output adft_pkg::t_out   o_out
);
    import adft_pkg::*;

    logic  push, pop, full, accept;
    t_job  job;
    t_head head;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    adft_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_in       (i_in),
        .o_push     (push),
        .o_job      (job)
    );

    adft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    adft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // The DAC clear beat is always the first alarm byte
    a_clr_is_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.dac_clear |-> o_out.tx_byte == AlarmByte && !o_out.last)
        else $error("dac_clear on a non-alarm byte");

    // Every run ends in a zero padding byte
    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.last |-> o_out.tx_byte == 8'd0 && !o_out.dac_clear)
        else $error("last on a non-padding byte");

    // The first alarm byte (dac_clear), once taken, is followed by more of the run
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out.dac_clear |=> o_out_valid)
        else $error("run broken after dac_clear");

endmodule

/* rtl/adft_front.sv */
module adft_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_accept,
    input  adft_pkg::t_in        i_in,
    output logic                 o_push,
    output adft_pkg::t_job       o_job
);
    import adft_pkg::*;

    logic [7:0]  r_volt_ch, r_temp_ch;
    logic [15:0] r_decimate, r_trip;
    logic [11:0] r_vlimit;
    logic [15:0] r_vskip, r_tskip, r_exceed, r_within;
    logic [15:0] n_vskip, n_tskip, n_exceed, n_within;
    logic [15:0] within_inc;
    logic        is_temp, is_volt, temp_hit, volt_hit, over, alarm;

    // Classify the beat and work out counter updates
    always_comb begin
        is_temp    = (i_in.channel == r_temp_ch);
        is_volt    = !is_temp && (i_in.channel == r_volt_ch);
        temp_hit   = is_temp && (r_tskip == r_decimate);
        volt_hit   = is_volt && (r_vskip == r_decimate);
        over       = (i_in.sample > r_vlimit);
        alarm      = volt_hit && over && (r_exceed == r_trip);
        within_inc = r_within + 16'd1;

        n_tskip  = r_tskip;
        n_vskip  = r_vskip;
        n_exceed = r_exceed;
        n_within = r_within;

        if (is_temp) begin
            n_tskip = temp_hit ? 16'd0 : r_tskip + 16'd1;
        end
        if (is_volt) begin
            n_vskip = volt_hit ? 16'd0 : r_vskip + 16'd1;
        end
        // Over-limit qualifier runs only on decimated voltage samples
        if (volt_hit) begin
            if (over) begin
                n_exceed = alarm ? 16'd0 : r_exceed + 16'd1;
            end else if (within_inc == r_trip) begin
                n_within = 16'd0;
                n_exceed = 16'd0;
            end else begin
                n_within = within_inc;
            end
        end
    end

    assign o_push        = i_accept && (temp_hit || volt_hit);
    assign o_job.alarm   = alarm;
    assign o_job.channel = i_in.channel;
    assign o_job.sample  = i_in.sample;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_ch  <= RstVoltCh;
            r_temp_ch  <= RstTempCh;
            r_decimate <= RstDecimate;
            r_vlimit   <= RstVLimit;
            r_trip     <= RstTrip;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_VOLT_CH:  r_volt_ch  <= i_cfg_data[7:0];
                CFG_TEMP_CH:  r_temp_ch  <= i_cfg_data[7:0];
                CFG_DECIMATE: r_decimate <= i_cfg_data;
                CFG_VLIMIT:   r_vlimit   <= i_cfg_data[11:0];
                CFG_TRIP:     r_trip     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance counters on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vskip  <= '0;
            r_tskip  <= '0;
            r_exceed <= '0;
            r_within <= '0;
        end else if (i_accept) begin
            r_vskip  <= n_vskip;
            r_tskip  <= n_tskip;
            r_exceed <= n_exceed;
            r_within <= n_within;
        end
    end

endmodule

/* rtl/adft_queue.sv */
module adft_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  adft_pkg::t_job   i_job,
    input  logic             i_pop,
    output logic             o_full,
    output adft_pkg::t_head  o_head
);
    import adft_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    t_job             r_mem [QueueDepth];
    logic [PtrW-1:0]  r_wp, r_rp;
    logic [PtrW:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full       = (r_cnt == (PtrW+1)'(QueueDepth));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_mem[r_rp];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PtrW'(QueueDepth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PtrW'(QueueDepth - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/adft_back.sv */
module adft_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  adft_pkg::t_head  i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output adft_pkg::t_out   o_out
);
    import adft_pkg::*;

    localparam logic [PosW-1:0] LastPos  = PosW'(2 * FrameLen - 1);
    localparam logic [PosW-1:0] DataPos  = PosW'(FrameLen);

    logic [PosW-1:0] r_pos;
    logic            r_active;
    logic            r_out_valid;
    t_out            r_out;
    logic [PosW-1:0] pos;
    logic [3:0]      k;
    logic            advance;
    t_out            n_out;

    // Current byte position: a fresh job without alarm starts at the data frame
    always_comb begin
        pos     = r_active ? r_pos : (i_head.job.alarm ? '0 : DataPos);
        k       = pos[3:0];
        advance = !r_out_valid || i_out_ready;
        o_pop   = advance && i_head.valid && (pos == LastPos);

        n_out.last      = (pos == LastPos);
        n_out.dac_clear = (pos == '0);
        n_out.tx_byte   = '0;
        if (!pos[PosW-1]) begin
            if (k < 4'(AlarmHead)) begin
                n_out.tx_byte = AlarmByte;
            end
        end else begin
            unique case (k)
                4'd0:    n_out.tx_byte = i_head.job.channel;
                4'd1:    n_out.tx_byte = i_head.job.sample[7:0];
                4'd2:    n_out.tx_byte = {4'b0, i_head.job.sample[11:8]};
                default: n_out.tx_byte = '0;
            endcase
        end
    end

    // Serialize the head job one beat per cycle into the output register while not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_head.valid;
            if (i_head.valid) begin
                if (pos == LastPos) begin
                    r_active <= 1'b0;
                end else begin
                    r_active <= 1'b1;
                    r_pos    <= pos + 1'b1;
                end
            end
        end
    end

    // Hold the payload until taken
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
